FILE: hw/rtl/jmsp_pkg.sv
`default_nettype none

package jmsp_pkg;

    // Player count and derived widths
    localparam int Players    = 4;
    localparam int PlayerW    = 3;
    localparam int PlayerIdxW = (Players > 1) ? $clog2(Players) : 1;

    // Stream and config widths
    localparam int SDataW = 16;
    localparam int SUserW = 2;
    localparam int MDataW = 16;
    localparam int CfgW   = 3;

    // Port constants
    localparam logic [1:0] SelResetVal = 2'b11;
    localparam logic [3:0] LinesIdle   = 4'hF;
    localparam logic [1:0] ReadTopBits = 2'b11;
    localparam logic [2:0] MpCountRst  = 3'd1;

    typedef enum logic [1:0] {
        KIND_READ      = 2'd0,
        KIND_MP_READ   = 2'd1,
        KIND_SEL_WRITE = 2'd2,
        KIND_BUTTON    = 2'd3
    } kind_t;

    typedef logic [3:0] nibble_t;

endpackage

`default_nettype wire

FILE: hw/rtl/joypad_matrix_select_port.sv
// Channel  | Ports                          | Contents (lowest bit up)
// ---------+--------------------------------+----------------------------------------------
// input    | s_tvalid s_tready s_tdata/tuser| tuser: kind[1:0]
//          |                                | tdata: value[7:0] player[10:8] button[13:11]
//          |                                |        pressed[14] zero[15]
// result   | m_tvalid m_tready m_tdata      | tdata: read_data[7:0] irq_request[8] zero[15:9]
// config   | cfg_valid cfg_ready cfg_data   | multiplayer_count[2:0], always ready
//
// One item per cycle while the result is not stalled; an accepted item passes the input register,
// then the port logic into a result register, which drives m_tvalid.
// A stalled result register holds the item; the input register still takes one more item.
// Reset (aresetn low, synchronous) releases all buttons, deselects both groups and sets
// multiplayer_count to one.
`default_nettype none

module joypad_matrix_select_port (
    input  wire                        aclk,
    input  wire                        aresetn,
    // kind[1:0]
    input  wire [jmsp_pkg::SUserW-1:0] s_tuser,
    // value[7:0], player[10:8], button[13:11], pressed[14], zero[15]
    input  wire [jmsp_pkg::SDataW-1:0] s_tdata,
    input  wire                        s_tvalid,
    output logic                       s_tready,
    // read_data[7:0], irq_request[8], zero[15:9]
    output logic [jmsp_pkg::MDataW-1:0] m_tdata,
    output logic                        m_tvalid,
    input  wire                         m_tready,
    input  wire [jmsp_pkg::CfgW-1:0]    cfg_data,
    input  wire                         cfg_valid,
    output logic                        cfg_ready
);
    import jmsp_pkg::*;

    // Input register
    logic                 in_valid_reg, in_valid_next;
    kind_t                in_kind_reg;
    logic [7:0]           in_value_reg;
    logic [PlayerW-1:0]   in_player_reg;
    logic [2:0]           in_button_reg;
    logic                 in_pressed_reg;

    // Port state
    logic [CfgW-1:0]      mp_count_reg;
    logic [1:0]           sel_reg, sel_next;
    nibble_t              dir_reg [Players];
    nibble_t              act_reg [Players];
    nibble_t              dir_next, act_next;
    logic                 nib_we;

    // Result register
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_data_reg, out_data_next;
    logic                 out_irq_reg, out_irq_next;

    logic                 advance, take, fire;
    logic [PlayerIdxW-1:0] idx;
    logic                 player_ok;

    function automatic nibble_t lines_f(input logic [1:0] sel, input nibble_t dir,
                                        input nibble_t act);
        nibble_t l;
        l = LinesIdle;
        if (!sel[0]) l = l & ~dir;
        if (!sel[1]) l = l & ~act;
        return l;
    endfunction

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign take      = s_tvalid && s_tready;
    assign fire      = in_valid_reg && advance;
    assign in_valid_next  = take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = fire ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    assign idx       = in_player_reg[PlayerIdxW-1:0];
    assign player_ok = in_player_reg < PlayerW'(Players);

    // Port logic: read value, state update and falling-line detect
    always_comb begin
        nibble_t    lines_pre;
        nibble_t    lines_post;
        nibble_t    mask;
        nibble_t    cur_dir;
        nibble_t    cur_act;
        cur_dir       = dir_reg[idx];
        cur_act       = act_reg[idx];
        lines_pre     = player_ok ? lines_f(sel_reg, cur_dir, cur_act) : LinesIdle;
        lines_post    = lines_pre;
        mask          = nibble_t'(4'b0001 << in_button_reg[1:0]);
        sel_next      = sel_reg;
        dir_next      = cur_dir;
        act_next      = cur_act;
        nib_we        = 1'b0;
        out_data_next = 8'h00;
        out_irq_next  = 1'b0;
        unique case (in_kind_reg)
            KIND_READ: begin
                out_data_next = {ReadTopBits, sel_reg,
                                 lines_f(sel_reg, dir_reg[0], act_reg[0])};
            end
            KIND_MP_READ: begin
                if (mp_count_reg > CfgW'(1) && sel_reg == SelResetVal) begin
                    out_data_next = {ReadTopBits, sel_reg, LinesIdle - nibble_t'(in_player_reg)};
                end else begin
                    out_data_next = {ReadTopBits, sel_reg, lines_pre};
                end
            end
            KIND_SEL_WRITE: begin
                sel_next = in_value_reg[5:4];
                if (player_ok) lines_post = lines_f(sel_next, cur_dir, cur_act);
                out_irq_next = |(lines_pre & ~lines_post);
            end
            KIND_BUTTON: begin
                if (player_ok) begin
                    nib_we = 1'b1;
                    if (!in_button_reg[2]) begin
                        dir_next = in_pressed_reg ? (cur_dir | mask) : (cur_dir & ~mask);
                    end else begin
                        act_next = in_pressed_reg ? (cur_act | mask) : (cur_act & ~mask);
                    end
                    lines_post = lines_f(sel_reg, dir_next, act_next);
                end
                out_irq_next = |(lines_pre & ~lines_post);
            end
            default: ;
        endcase
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mp_count_reg  <= MpCountRst;
            sel_reg       <= SelResetVal;
            for (int i = 0; i < Players; i++) begin
                dir_reg[i] <= '0;
                act_reg[i] <= '0;
            end
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) mp_count_reg <= cfg_data;
            if (fire) begin
                sel_reg <= sel_next;
                if (nib_we) begin
                    dir_reg[idx] <= dir_next;
                    act_reg[idx] <= act_next;
                end
            end
        end
    end

    // Payload registers: capture on accept, hold on stall
    always_ff @(posedge aclk) begin
        if (take) begin
            in_kind_reg    <= kind_t'(s_tuser);
            in_value_reg   <= s_tdata[7:0];
            in_player_reg  <= s_tdata[10:8];
            in_button_reg  <= s_tdata[13:11];
            in_pressed_reg <= s_tdata[14];
        end
        if (fire) begin
            out_data_reg <= out_data_next;
            out_irq_reg  <= out_irq_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_irq_reg, out_data_reg};

endmodule

`default_nettype wire

FILE: hw/rtl/jmsp_checker.sv
`default_nettype none

module jmsp_checker (
    input wire                        aclk,
    input wire                        aresetn,
    input wire                        s_tready,
    input wire [jmsp_pkg::MDataW-1:0] m_tdata,
    input wire                        m_tvalid,
    input wire                        m_tready
);
    import jmsp_pkg::*;

    // Stalled result holds its item
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // No result in the cycle after reset
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // An interrupt comes only with a zero read value
    a_irq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] |-> m_tdata[7:0] == 8'h00)
        else $error("irq with read data");

    // Nonzero read data always carries the fixed top bits, padding is zero
    a_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[MDataW-1:9] == '0 &&
                     (m_tdata[7:0] == 8'h00 || m_tdata[7:6] == ReadTopBits))
        else $error("malformed read data");

    // Input backs off only behind a stalled result
    a_backoff: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a stalled result");

endmodule

bind joypad_matrix_select_port jmsp_checker u_jmsp_checker (.*);

`default_nettype wire

FILE: verif/joypad_matrix_select_port_tb.sv
`timescale 1ns / 100ps

module joypad_matrix_select_port_tb;

    import jmsp_pkg::*;

    localparam int HoldCycles = 60;
    localparam int StallLimit = 500;
    localparam int PhaseItems = 330;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        logic [2:0] player;
        logic [2:0] button;
        logic       pressed;
    } port_op_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_request;
    } port_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic [SUserW-1:0]  s_tuser = '0;
    logic [SDataW-1:0]  s_tdata = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [MDataW-1:0]  m_tdata;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [CfgW-1:0]    cfg_data = '0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;

    // Port state as the block should hold it
    logic [2:0]         mp_count;
    logic [1:0]         group_sel;
    nibble_t            dir_held [Players];
    nibble_t            act_held [Players];

    port_op_t           port_ops_q [$];
    port_result_t       port_results_q [$];
    port_op_t           op_on_bus;
    logic               op_holding = 1'b0;

    int                 tx_gap = 0;
    int                 rx_gap = 0;
    logic               no_idle = 1'b0;
    int                 hold_req_cnt = 0;
    int                 hold_ack_cnt = 0;
    int                 hold_left = 0;
    int                 stall_cnt = 0;

    int                 err_cnt = 0;
    int                 n_sent = 0;
    int                 n_checked = 0;
    int                 n_irq = 0;
    int                 n_id_reads = 0;

    joypad_matrix_select_port u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Lines of one player under the current group select
    function automatic nibble_t lines_seen(input logic [2:0] plr);
        nibble_t lines;
        lines = LinesIdle;
        if (int'(plr) >= Players) begin
            return LinesIdle;
        end
        if (!group_sel[0]) begin
            lines = lines & ~dir_held[plr[1:0]];
        end
        if (!group_sel[1]) begin
            lines = lines & ~act_held[plr[1:0]];
        end
        return lines;
    endfunction

    // Apply one accepted item to the port state and queue its result
    function automatic void predict_port(input port_op_t op);
        port_result_t res;
        nibble_t      lines_old;
        nibble_t      lines_new;
        res = '0;
        case (op.kind)
            KIND_READ: begin
                res.read_data = {ReadTopBits, group_sel, lines_seen(3'd0)};
            end
            KIND_MP_READ: begin
                if (mp_count > 3'd1 && group_sel == SelResetVal) begin
                    res.read_data = {ReadTopBits, group_sel, 4'hF - {1'b0, op.player}};
                    n_id_reads++;
                end else begin
                    res.read_data = {ReadTopBits, group_sel, lines_seen(op.player)};
                end
            end
            KIND_SEL_WRITE: begin
                lines_old = lines_seen(op.player);
                group_sel = op.value[5:4];
                lines_new = lines_seen(op.player);
                res.irq_request = |(lines_old & ~lines_new);
            end
            default: begin
                if (int'(op.player) < Players) begin
                    lines_old = lines_seen(op.player);
                    if (!op.button[2]) begin
                        dir_held[op.player[1:0]][op.button[1:0]] = op.pressed;
                    end else begin
                        act_held[op.player[1:0]][op.button[1:0]] = op.pressed;
                    end
                    lines_new = lines_seen(op.player);
                    res.irq_request = |(lines_old & ~lines_new);
                end
            end
        endcase
        if (res.irq_request) begin
            n_irq++;
        end
        port_results_q.push_back(res);
    endfunction

    function automatic void push_op(input kind_t k, input logic [7:0] v, input logic [2:0] p,
                                    input logic [2:0] b, input logic pr);
        port_op_t op;
        op.kind    = k;
        op.value   = v;
        op.player  = p;
        op.button  = b;
        op.pressed = pr;
        port_ops_q.push_back(op);
    endfunction

    // Random item, mostly for valid players
    function automatic void push_random_op();
        logic [2:0] plr;
        if ($urandom_range(0, 9) == 0) begin
            plr = 3'($urandom_range(4, 7));
        end else begin
            plr = 3'($urandom_range(0, 3));
        end
        push_op(kind_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), plr,
                3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    endfunction

    // Driver: present queued items, idle in random bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap   <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_port(op_on_bus);
                n_sent++;
                op_holding = 1'b0;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap != 0) begin
                    tx_gap   <= tx_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (port_ops_q.size() != 0 && !no_idle
                             && $urandom_range(0, 5) == 0) begin
                    tx_gap   <= $urandom_range(0, 10);
                    s_tvalid <= 1'b0;
                end else if (port_ops_q.size() != 0) begin
                    op_on_bus  = port_ops_q.pop_front();
                    op_holding = 1'b1;
                    s_tvalid   <= 1'b1;
                    s_tuser    <= op_on_bus.kind;
                    s_tdata    <= {1'b0, op_on_bus.pressed, op_on_bus.button,
                                   op_on_bus.player, op_on_bus.value};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result item, stall in random bursts or long holds
    always @(posedge aclk) begin
        port_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_checked++;
                if (port_results_q.size() == 0) begin
                    $display("%0t: result with none expected, actual %04h", $time, m_tdata);
                    err_cnt++;
                end else begin
                    want = port_results_q.pop_front();
                    if (m_tdata[7:0] !== want.read_data) begin
                        $display("%0t: read_data mismatch, expected %02h, actual %02h",
                                 $time, want.read_data, m_tdata[7:0]);
                        err_cnt++;
                    end
                    if (m_tdata[8] !== want.irq_request) begin
                        $display("%0t: irq_request mismatch, expected %0b, actual %0b",
                                 $time, want.irq_request, m_tdata[8]);
                        err_cnt++;
                    end
                    if (m_tdata[15:9] !== 7'd0) begin
                        $display("%0t: pad bits mismatch, expected 00, actual %02h",
                                 $time, m_tdata[15:9]);
                        err_cnt++;
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if (hold_ack_cnt != hold_req_cnt) begin
                hold_ack_cnt <= hold_ack_cnt + 1;
                hold_left    <= HoldCycles;
                m_tready     <= 1'b0;
            end else if (rx_gap != 0) begin
                rx_gap   <= rx_gap - 1;
                m_tready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 4) == 0) begin
                rx_gap   <= $urandom_range(0, 10);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= StallLimit) begin
            $display("%0t: no item accepted for %0d cycles", $time, StallLimit);
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    // Hold until every queued item has gone in and every result has come out
    task automatic wait_drained();
        @(posedge aclk);
        while (port_ops_q.size() != 0 || op_holding || port_results_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_mp_count(input logic [2:0] cnt);
        cfg_valid <= 1'b1;
        cfg_data  <= cnt;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        mp_count = cnt;
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [2:0] phase_counts [6];
        phase_counts = '{3'd0, 3'd4, 3'd2, 3'd7, 3'd3, 3'd1};

        mp_count  = MpCountRst;
        group_sel = SelResetVal;
        for (int i = 0; i < Players; i++) begin
            dir_held[i] = '0;
            act_held[i] = '0;
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset state, single player: selects, reads, invalid players
        push_op(KIND_READ,      8'h00, 3'd5, 3'd0, 1'b0);
        push_op(KIND_MP_READ,   8'h00, 3'd7, 3'd0, 1'b0);
        push_op(KIND_BUTTON,    8'h00, 3'd0, 3'd0, 1'b1);
        push_op(KIND_BUTTON,    8'h00, 3'd0, 3'd7, 1'b1);
        push_op(KIND_SEL_WRITE, 8'h00, 3'd0, 3'd0, 1'b0);
        push_op(KIND_READ,      8'hFF, 3'd3, 3'd0, 1'b0);
        push_op(KIND_SEL_WRITE, 8'hEF, 3'd0, 3'd0, 1'b0);
        push_op(KIND_BUTTON,    8'h00, 3'd0, 3'd3, 1'b1);
        push_op(KIND_MP_READ,   8'h00, 3'd0, 3'd0, 1'b0);
        push_op(KIND_BUTTON,    8'h00, 3'd3, 3'd4, 1'b1);
        push_op(KIND_BUTTON,    8'h00, 3'd3, 3'd5, 1'b1);
        push_op(KIND_SEL_WRITE, 8'hDF, 3'd3, 3'd0, 1'b0);
        push_op(KIND_MP_READ,   8'h00, 3'd3, 3'd0, 1'b0);
        push_op(KIND_BUTTON,    8'h00, 3'd6, 3'd2, 1'b1);
        push_op(KIND_SEL_WRITE, 8'hFF, 3'd5, 3'd0, 1'b0);
        push_op(KIND_MP_READ,   8'h00, 3'd4, 3'd0, 1'b0);
        push_op(KIND_BUTTON,    8'h00, 3'd0, 3'd0, 1'b0);
        push_op(KIND_BUTTON,    8'h00, 3'd0, 3'd3, 1'b0);
        wait_drained();

        // Four players, both groups deselected: identification reads
        write_mp_count(3'd4);
        for (int p = 0; p < 8; p++) begin
            push_op(KIND_MP_READ, 8'h00, 3'(p), 3'd0, 1'b0);
        end
        push_op(KIND_SEL_WRITE, 8'h10, 3'd3, 3'd0, 1'b0);
        push_op(KIND_MP_READ,   8'h00, 3'd3, 3'd0, 1'b0);
        push_op(KIND_SEL_WRITE, 8'h30, 3'd3, 3'd0, 1'b0);
        wait_drained();

        // Random phases, one player count each; the last runs without idling
        for (int ph = 0; ph < 6; ph++) begin
            write_mp_count(phase_counts[ph]);
            if (ph == 5) begin
                no_idle <= 1'b1;
            end
            for (int i = 0; i < PhaseItems / 2; i++) begin
                push_random_op();
            end
            wait_drained();
            for (int i = 0; i < PhaseItems - PhaseItems / 2; i++) begin
                push_random_op();
            end
            if (ph == 1 || ph == 3) begin
                hold_req_cnt <= hold_req_cnt + 1;
            end
            wait_drained();
        end

        repeat (6) @(posedge aclk);
        $display("Covered %0d items over player counts 0 to 7, %0d results checked,",
                 n_sent, n_checked);
        $display("with %0d interrupt requests and %0d identification reads", n_irq, n_id_reads);
        if (err_cnt == 0 && port_results_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
